// ===== rtl/qclt_pkg.sv =====
// ----------------------------------------------------------------------------
// qclt_pkg
// Shared types and constants of the quoted command line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qclt_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic REC_TOKEN = 1'b0;
	localparam logic REC_DONE  = 1'b1;

	localparam logic [6:0] MAX_TOKENS_RST  = 7'd16;
	localparam logic [1:0] ADDR_MAX_TOKENS = 2'd0;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNCLOSED = 3'd1,
		ST_NO_SPACE = 3'd2,
		ST_TOO_MANY = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	typedef struct packed {
		logic       has_tok;
		logic [5:0] idx;
		logic [7:0] start;
		logic [7:0] len;
		logic       has_done;
		status_t    status;
		logic [6:0] count;
	} qclt_entry_t;

endpackage

`default_nettype wire

// ===== rtl/qclt_front.sv =====
// ----------------------------------------------------------------------------
// qclt_front
// Line scanner: takes one character per beat, tracks quote and token state
// and produces the result entry of that character.
// ----------------------------------------------------------------------------
`default_nettype none

module qclt_front import qclt_pkg::*; #(
	parameter int LINE_MAX = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  ch,
	input  wire logic [6:0]  max_tokens,
	output logic             push,
	output qclt_entry_t      entry
);

	localparam int PW = $clog2(LINE_MAX);
	localparam logic [PW-1:0] POS_LAST = PW'(LINE_MAX - 1);

	logic          inq_q, intok_q, popen_q, pclose_q;
	logic [PW-1:0] begin_q, pos_q;
	logic [6:0]    cnt_q;
	status_t       err_q;

	logic          inq_n, intok_n, popen_n, pclose_n;
	logic [PW-1:0] begin_n, pos_n;
	logic [6:0]    cnt_n;
	status_t       err_n;

	logic          tok, eol;
	logic [PW-1:0] len_w;
	logic [PW+7:0] begin_ext, len_ext;
	logic [6:0]    cnt_inc;

	always_comb begin
		inq_n    = inq_q;
		intok_n  = intok_q;
		popen_n  = popen_q;
		pclose_n = pclose_q;
		begin_n  = begin_q;
		pos_n    = pos_q;
		cnt_n    = cnt_q;
		err_n    = err_q;
		tok      = 1'b0;
		eol      = 1'b0;
		len_w    = pos_q - begin_q - {{(PW-1){1'b0}}, pclose_q};
		cnt_inc  = cnt_q + 7'd1;
		if (ch == CH_NUL) begin
			eol = 1'b1;
			if (err_q == ST_OK) begin
				if (pclose_q) begin
					tok = (len_w != '0);
					if (tok) begin
						cnt_n = cnt_inc;
					end
					if (cnt_n >= max_tokens) begin
						err_n = ST_TOO_MANY;
					end
				end else if (inq_q || popen_q) begin
					err_n = ST_UNCLOSED;
				end else if (intok_q) begin
					tok   = 1'b1;
					cnt_n = cnt_inc;
				end
			end
		end else if (pos_q >= POS_LAST) begin
			err_n = ST_TOO_LONG;
		end else if (err_q != ST_OK) begin
			pos_n = pos_q + PW'(1);
		end else begin
			popen_n = 1'b0;
			pos_n   = pos_q + PW'(1);
			if (pclose_q) begin
				pclose_n = 1'b0;
				if (ch != CH_SPACE) begin
					err_n = ST_NO_SPACE;
				end else begin
					intok_n = 1'b0;
					tok     = (len_w != '0);
					if (tok) begin
						cnt_n = cnt_inc;
					end
				end
			end else if (inq_q) begin
				if (ch == CH_QUOTE) begin
					inq_n    = 1'b0;
					pclose_n = 1'b1;
				end
			end else if (ch == CH_SPACE) begin
				if (intok_q) begin
					tok     = 1'b1;
					cnt_n   = cnt_inc;
					intok_n = 1'b0;
				end
			end else if (ch == CH_QUOTE) begin
				begin_n = pos_q + PW'(1);
				inq_n   = 1'b1;
				intok_n = 1'b1;
				popen_n = 1'b1;
			end else if (!intok_q) begin
				begin_n = pos_q;
				intok_n = 1'b1;
			end
			if (err_n == ST_OK && cnt_n >= max_tokens) begin
				err_n = ST_TOO_MANY;
			end
		end
	end

	assign begin_ext = {8'd0, begin_q};
	assign len_ext   = {8'd0, len_w};

	always_comb begin
		entry.has_tok  = tok;
		entry.idx      = cnt_q[5:0];
		entry.start    = begin_ext[7:0];
		entry.len      = len_ext[7:0];
		entry.has_done = eol;
		entry.status   = err_n;
		entry.count    = cnt_n;
	end

	assign push = accept && (tok || eol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_q    <= 1'b0;
			intok_q  <= 1'b0;
			popen_q  <= 1'b0;
			pclose_q <= 1'b0;
			begin_q  <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
			err_q    <= ST_OK;
		end else if (accept) begin
			if (eol) begin
				inq_q    <= 1'b0;
				intok_q  <= 1'b0;
				popen_q  <= 1'b0;
				pclose_q <= 1'b0;
				begin_q  <= '0;
				pos_q    <= '0;
				cnt_q    <= '0;
				err_q    <= ST_OK;
			end else begin
				inq_q    <= inq_n;
				intok_q  <= intok_n;
				popen_q  <= popen_n;
				pclose_q <= pclose_n;
				begin_q  <= begin_n;
				pos_q    <= pos_n;
				cnt_q    <= cnt_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qclt_queue.sv =====
// ----------------------------------------------------------------------------
// qclt_queue
// Short queue of result entries between the scanner and the record output.
// ----------------------------------------------------------------------------
`default_nettype none

module qclt_queue import qclt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire qclt_entry_t  wr_entry,
	input  wire logic         pop,
	output qclt_entry_t       rd_entry,
	output logic              nonempty,
	output logic              full
);

	qclt_entry_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push, do_pop;

	assign nonempty = (fill_q != '0);
	assign full     = (fill_q == QCNT_W'(QDEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qclt_back.sv =====
// ----------------------------------------------------------------------------
// qclt_back
// Record output: unpacks each queued entry into its token record, its done
// record or both, and holds the current record until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module qclt_back import qclt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_nonempty,
	input  wire qclt_entry_t q_entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             record_kind,
	output logic [5:0]       token_index,
	output logic [7:0]       token_pos,
	output logic [7:0]       token_length,
	output logic [2:0]       status,
	output logic [6:0]       token_count
);

	qclt_entry_t ent_q;
	logic        busy_q, done_ph_q;
	logic        take, last;

	assign take = busy_q && !out_stall;
	assign last = done_ph_q || !ent_q.has_done;
	assign pop  = q_nonempty && (!busy_q || (take && last));

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_ph_q <= 1'b0;
		end else if (pop) begin
			busy_q    <= 1'b1;
			done_ph_q <= !q_entry.has_tok;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				done_ph_q <= 1'b1;
			end
		end
	end

	assign out_valid    = busy_q;
	assign record_kind  = done_ph_q ? REC_DONE : REC_TOKEN;
	assign token_index  = done_ph_q ? 6'd0 : ent_q.idx;
	assign token_pos    = done_ph_q ? 8'd0 : ent_q.start;
	assign token_length = done_ph_q ? 8'd0 : ent_q.len;
	assign status       = done_ph_q ? ent_q.status : ST_OK;
	assign token_count  = done_ph_q ? ent_q.count : 7'd0;

endmodule

`default_nettype wire

// ===== rtl/quoted_command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer
// Splits a command line, one character per beat, into space separated and
// quoted tokens; reports each token and a done record at the end of line.
//
//   channel  handshake                 payload
//   in       in_valid / in_stall       ch
//   out      out_valid / out_stall     record_kind token_index token_pos
//                                      token_length status token_count
//   cfg      psel penable pwrite pready paddr pwdata prdata (max_tokens @ 0)
//
// One character is taken every cycle while in_stall is low; each gives zero
// or one record, the end of line one or two, which the output side sends one
// per cycle while out_stall is low. A four-entry queue between scanner and
// output lets each side stall alone; in_stall rises only when it is full.
// Reset clears the line state and sets max_tokens to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_command_line_tokenizer import qclt_pkg::*; #(
	parameter int LINE_MAX = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             record_kind,
	output logic [5:0]       token_index,
	output logic [7:0]       token_pos,
	output logic [7:0]       token_length,
	output logic [2:0]       status,
	output logic [6:0]       token_count,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [6:0]  max_tokens_q;
	logic        accept, push, pop, q_nonempty, q_full;
	qclt_entry_t push_entry, head_entry;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_TOKENS) ? {25'd0, max_tokens_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_TOKENS) begin
			max_tokens_q <= pwdata[6:0];
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	qclt_front #(
		.LINE_MAX(LINE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ch        (ch),
		.max_tokens(max_tokens_q),
		.push      (push),
		.entry     (push_entry)
	);

	qclt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(push_entry),
		.pop     (pop),
		.rd_entry(head_entry),
		.nonempty(q_nonempty),
		.full    (q_full)
	);

	qclt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_entry     (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.record_kind (record_kind),
		.token_index (token_index),
		.token_pos   (token_pos),
		.token_length(token_length),
		.status      (status),
		.token_count (token_count)
	);

endmodule

`default_nettype wire
